>>> sv/ppa_pkg.sv
// Shared constants, codes and types of the physical page allocator.
// No dependencies; the match unit, the top level and the checker refer to it by scoped names.
package ppa_pkg;

    // Fixed field widths of the request and result channels.
    localparam int FUNC_W     = 2;
    localparam int OWNER_IN_W = 8;
    localparam int VPAGE_W    = 20;
    localparam int STATUS_W   = 2;
    localparam int PAGE_W     = 10;
    localparam int COUNT_W    = 11;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;

    // Operation codes carried in the func field.
    localparam logic [FUNC_W-1:0] FUNC_BEGIN  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_PROTO = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_PAGE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PAGES = 1'd1;

    // Decision of the match unit for one frame read back from the table.
    typedef struct packed {
        logic stop;       // allocation found its free frame
        logic owner_we;   // rewrite the owner tag of this frame
        logic vpage_we;   // rewrite the virtual page of this frame
        logic count_inc;  // frame released by a free request
    } match_ctl_t;

endpackage

>>> sv/ppa_frame_table.sv
// Owner tag and virtual page store, one entry per physical frame.
// Depends on nothing but its parameters; one write port, one registered read port.
module ppa_frame_table #(
    parameter int FRAMES     = 1024,
    parameter int OWNER_BITS = 8,
    parameter int VPAGE_W    = 20,
    parameter int AW         = $clog2(FRAMES)
) (
    input  logic                  aclk,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output logic [OWNER_BITS-1:0] rd_owner,
    input  logic                  wr_owner_en,
    input  logic                  wr_vpage_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [OWNER_BITS-1:0] wr_owner,
    input  logic [VPAGE_W-1:0]    wr_vpage
);

    logic [OWNER_BITS-1:0] owner_mem [FRAMES];
    logic [VPAGE_W-1:0]    vpage_mem [FRAMES];

    // Owner tags: written by the sequencer, read one frame per cycle while rd_en is high.
    always_ff @(posedge aclk) begin
        if (wr_owner_en) begin
            owner_mem[wr_addr] <= wr_owner;
        end
        if (rd_en) begin
            rd_owner <= owner_mem[rd_addr];
        end
    end

    // Virtual page recorded for each frame.
    always_ff @(posedge aclk) begin
        if (wr_vpage_en) begin
            vpage_mem[wr_addr] <= wr_vpage;
        end
    end

endmodule

>>> sv/ppa_match_unit.sv
// Shared compare unit: decides what happens to one frame read from the table.
// Depends on ppa_pkg for the operation codes and the match_ctl_t type.
module ppa_match_unit #(
    parameter int OWNER_BITS = 8
) (
    input  logic                          valid,
    input  logic [ppa_pkg::FUNC_W-1:0]    func,
    input  logic                          commit,
    input  logic [OWNER_BITS-1:0]         req_owner,
    input  logic [OWNER_BITS-1:0]         open_owner,
    input  logic [OWNER_BITS-1:0]         frame_owner,
    output ppa_pkg::match_ctl_t           ctl,
    output logic [OWNER_BITS-1:0]         owner_wdata
);

    localparam logic [OWNER_BITS-1:0] PENDING_TAG = '1;

    // One comparison per frame; the tag it looks for depends on the request.
    always_comb begin
        ctl         = '0;
        owner_wdata = '0;
        unique case (func)
            ppa_pkg::FUNC_ALLOC: begin
                owner_wdata  = PENDING_TAG;
                ctl.stop     = valid && (frame_owner == '0);
                ctl.owner_we = ctl.stop;
                ctl.vpage_we = ctl.stop;
            end
            ppa_pkg::FUNC_FINISH: begin
                owner_wdata  = commit ? open_owner : '0;
                ctl.owner_we = valid && (frame_owner == PENDING_TAG);
                // A commit keeps the recorded virtual page.
                ctl.vpage_we = ctl.owner_we && !commit;
            end
            ppa_pkg::FUNC_FREE: begin
                ctl.owner_we  = valid && (frame_owner == req_owner);
                ctl.vpage_we  = ctl.owner_we;
                ctl.count_inc = ctl.owner_we;
            end
            default: begin
                ctl = '0;
            end
        endcase
    end

endmodule

>>> sv/physical_page_allocator_core.sv
// Top level of the physical page allocator: sequencer, registers and result stage.
// Depends on ppa_pkg, ppa_frame_table and ppa_match_unit.
//
// Usage. Requests arrive on the s_ channel (func, owner, vpage, commit) under
// valid/ready and each gives exactly one result on the m_ channel (status,
// page, count). The cfg channel writes first_page (index 0) and total_pages
// (index 1); it is always ready and must be used only while the block is idle.
// Begin, and any request refused with a protocol error, needs no scan: its
// result passes through the reply state to the output register. Alloc, finish
// and free walk the tracked frames through the single read port of the owner
// table, one frame per cycle; alloc stops at the first free frame. One request
// is in work at a time; s_ready is low while it runs, but a finished result
// may wait in the output register while the next request is accepted and
// scanned. When the receiver stalls, a result that has finished scanning waits
// until the output register empties. After reset the owner table is cleared
// one frame per cycle with s_ready low; configuration writes are taken during
// that pass.
module physical_page_allocator_core #(
    parameter int FRAMES     = 1024,
    parameter int OWNER_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ppa_pkg::FUNC_W-1:0]        s_func,
    input  logic [ppa_pkg::OWNER_IN_W-1:0]    s_owner,
    input  logic [ppa_pkg::VPAGE_W-1:0]       s_vpage,
    input  logic                              s_commit,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ppa_pkg::STATUS_W-1:0]      m_status,
    output logic [ppa_pkg::PAGE_W-1:0]        m_page,
    output logic [ppa_pkg::COUNT_W-1:0]       m_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ppa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppa_pkg::CFG_W-1:0]         cfg_data
);

    localparam int AW      = $clog2(FRAMES);
    localparam int CFG_W   = ppa_pkg::CFG_W;
    localparam int SCAN_W  = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam int PAGE_W  = ppa_pkg::PAGE_W;
    localparam int VPAGE_W = ppa_pkg::VPAGE_W;
    localparam int FUNC_W  = ppa_pkg::FUNC_W;
    localparam int COUNT_W = ppa_pkg::COUNT_W;
    localparam int STAT_W  = ppa_pkg::STATUS_W;

    localparam logic [SCAN_W-1:0]     FRAMES_S    = SCAN_W'(FRAMES);
    localparam logic [SCAN_W-1:0]     LAST_FRAME  = SCAN_W'(FRAMES - 1);
    localparam logic [OWNER_BITS-1:0] PENDING_TAG = '1;

    // Sequencer states.
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_REPLY = 2'd3;

    // Control registers.
    logic [1:0]            state_reg, state_next;
    logic [SCAN_W-1:0]     idx_reg, idx_next;
    logic                  issue_reg, issue_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic                  open_flag_reg, open_flag_next;
    logic [OWNER_BITS-1:0] open_owner_reg, open_owner_next;
    logic                  m_valid_reg, m_valid_next;
    logic [CFG_W-1:0]      first_page_reg, total_pages_reg;

    // Payload registers.
    logic [FUNC_W-1:0]     op_reg, op_next;
    logic [OWNER_BITS-1:0] owner_reg, owner_next;
    logic [VPAGE_W-1:0]    vpage_reg, vpage_next;
    logic                  commit_reg, commit_next;
    logic [AW-1:0]         rd_idx_reg, rd_idx_next;
    logic [STAT_W-1:0]     status_reg, status_next;
    logic [PAGE_W-1:0]     page_reg, page_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [STAT_W-1:0]     m_status_reg, m_status_next;
    logic [PAGE_W-1:0]     m_page_reg, m_page_next;
    logic [COUNT_W-1:0]    m_count_reg, m_count_next;

    // Working signals.
    logic [OWNER_BITS-1:0] owner_in;
    logic                  owner_bad;
    logic [SCAN_W-1:0]     first_s, total_s, range_end;
    logic                  scan_issue;
    logic                  out_free;
    logic [OWNER_BITS-1:0] rd_owner;
    logic [OWNER_BITS-1:0] match_wdata;
    ppa_pkg::match_ctl_t   ctl;
    logic                  wr_owner_en, wr_vpage_en;
    logic [AW-1:0]         wr_addr;
    logic [OWNER_BITS-1:0] wr_owner;
    logic [VPAGE_W-1:0]    wr_vpage;

    // Request owner at table width, and the reserved tags.
    assign owner_in  = OWNER_BITS'(s_owner);
    assign owner_bad = (owner_in == '0) || (owner_in == PENDING_TAG);

    // Tracked range, cut at the table size.
    assign first_s    = SCAN_W'(first_page_reg);
    assign total_s    = SCAN_W'(total_pages_reg);
    assign range_end  = (total_s < FRAMES_S) ? total_s : FRAMES_S;
    assign scan_issue = (state_reg == S_SCAN) && issue_reg && (idx_reg < range_end);

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_page    = m_page_reg;
    assign m_count   = m_count_reg;

    // Owner and virtual page store.
    ppa_frame_table #(
        .FRAMES     (FRAMES),
        .OWNER_BITS (OWNER_BITS),
        .VPAGE_W    (VPAGE_W),
        .AW         (AW)
    ) u_table (
        .aclk        (aclk),
        .rd_en       (scan_issue),
        .rd_addr     (idx_reg[AW-1:0]),
        .rd_owner    (rd_owner),
        .wr_owner_en (wr_owner_en),
        .wr_vpage_en (wr_vpage_en),
        .wr_addr     (wr_addr),
        .wr_owner    (wr_owner),
        .wr_vpage    (wr_vpage)
    );

    // Compare unit applied to the frame returned by the previous read.
    ppa_match_unit #(
        .OWNER_BITS (OWNER_BITS)
    ) u_match (
        .valid       (rd_vld_reg && (state_reg == S_SCAN)),
        .func        (op_reg),
        .commit      (commit_reg),
        .req_owner   (owner_reg),
        .open_owner  (open_owner_reg),
        .frame_owner (rd_owner),
        .ctl         (ctl),
        .owner_wdata (match_wdata)
    );

    // Table write port: the clearing pass after reset, otherwise the scan.
    always_comb begin
        if (state_reg == S_CLEAR) begin
            wr_owner_en = 1'b1;
            wr_vpage_en = 1'b1;
            wr_addr     = idx_reg[AW-1:0];
            wr_owner    = '0;
            wr_vpage    = '0;
        end else begin
            wr_owner_en = ctl.owner_we;
            wr_vpage_en = ctl.vpage_we;
            wr_addr     = rd_idx_reg;
            wr_owner    = match_wdata;
            wr_vpage    = (op_reg == ppa_pkg::FUNC_ALLOC) ? vpage_reg : '0;
        end
    end

    // Sequencer and result stage.
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        issue_next      = issue_reg;
        rd_vld_next     = rd_vld_reg;
        open_flag_next  = open_flag_reg;
        open_owner_next = open_owner_reg;
        m_valid_next    = m_valid_reg;
        op_next         = op_reg;
        owner_next      = owner_reg;
        vpage_next      = vpage_reg;
        commit_next     = commit_reg;
        rd_idx_next     = rd_idx_reg;
        status_next     = status_reg;
        page_next       = page_reg;
        count_next      = count_reg;
        m_status_next   = m_status_reg;
        m_page_next     = m_page_reg;
        m_count_next    = m_count_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                if (idx_reg == LAST_FRAME) begin
                    state_next = S_IDLE;
                    idx_next   = '0;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next     = s_func;
                    owner_next  = owner_in;
                    vpage_next  = s_vpage;
                    commit_next = s_commit;
                    idx_next    = first_s;
                    status_next = ppa_pkg::STATUS_OK;
                    page_next   = '0;
                    count_next  = '0;
                    rd_vld_next = 1'b0;
                    issue_next  = 1'b0;
                    state_next  = S_REPLY;
                    unique case (s_func)
                        ppa_pkg::FUNC_BEGIN: begin
                            if (open_flag_reg || owner_bad) begin
                                status_next = ppa_pkg::STATUS_PROTO;
                            end else begin
                                open_flag_next  = 1'b1;
                                open_owner_next = owner_in;
                            end
                        end
                        ppa_pkg::FUNC_ALLOC: begin
                            if (!open_flag_reg) begin
                                status_next = ppa_pkg::STATUS_PROTO;
                            end else begin
                                status_next = ppa_pkg::STATUS_FULL;
                                issue_next  = 1'b1;
                                state_next  = S_SCAN;
                            end
                        end
                        ppa_pkg::FUNC_FINISH: begin
                            if (!open_flag_reg) begin
                                status_next = ppa_pkg::STATUS_PROTO;
                            end else begin
                                issue_next = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                            if (owner_bad) begin
                                status_next = ppa_pkg::STATUS_PROTO;
                            end else begin
                                issue_next = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (ctl.count_inc) begin
                    count_next = count_reg + 1'b1;
                end
                if (ctl.stop) begin
                    // Allocation found its frame; the read in flight is dropped.
                    status_next = ppa_pkg::STATUS_OK;
                    page_next   = PAGE_W'(rd_idx_reg);
                    issue_next  = 1'b0;
                    rd_vld_next = 1'b0;
                    state_next  = S_REPLY;
                end else if (!scan_issue && !rd_vld_reg) begin
                    issue_next = 1'b0;
                    state_next = S_REPLY;
                    if (op_reg == ppa_pkg::FUNC_FINISH) begin
                        open_flag_next  = 1'b0;
                        open_owner_next = '0;
                    end
                end else begin
                    issue_next  = scan_issue;
                    rd_vld_next = scan_issue;
                    rd_idx_next = idx_reg[AW-1:0];
                    if (scan_issue) begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_page_next   = page_reg;
                    m_count_next  = count_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            idx_reg        <= '0;
            issue_reg      <= 1'b0;
            rd_vld_reg     <= 1'b0;
            open_flag_reg  <= 1'b0;
            open_owner_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            issue_reg      <= issue_next;
            rd_vld_reg     <= rd_vld_next;
            open_flag_reg  <= open_flag_next;
            open_owner_reg <= open_owner_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_page_reg  <= '0;
            total_pages_reg <= CFG_W'(1024);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ppa_pkg::REG_FIRST_PAGE:  first_page_reg  <= cfg_data;
                ppa_pkg::REG_TOTAL_PAGES: total_pages_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Request and result payload.
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        owner_reg    <= owner_next;
        vpage_reg    <= vpage_next;
        commit_reg   <= commit_next;
        rd_idx_reg   <= rd_idx_next;
        status_reg   <= status_next;
        page_reg     <= page_next;
        count_reg    <= count_next;
        m_status_reg <= m_status_next;
        m_page_reg   <= m_page_next;
        m_count_reg  <= m_count_next;
    end

endmodule

>>> sv/ppa_checker.sv
// Port-level checks of the physical page allocator, bound to its top level.
// Depends on ppa_pkg for widths and status codes.
module ppa_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [ppa_pkg::STATUS_W-1:0]      m_status,
    input logic [ppa_pkg::PAGE_W-1:0]        m_page,
    input logic [ppa_pkg::COUNT_W-1:0]       m_count
);

    // Reset empties the result register and holds off requests for the clearing pass.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("result or request ready straight after reset");

    // One request in work at a time: ready drops after every accepted request.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in work");

    // Only a successful allocation reports a frame number.
    a_page_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_page != '0) |-> m_status == ppa_pkg::STATUS_OK && m_count == '0)
        else $error("frame number reported with a failure or a release count");

    // Only a successful free reports a release count.
    a_count_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_count != '0) |-> m_status == ppa_pkg::STATUS_OK)
        else $error("release count reported with a failure status");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_page)
            && $stable(m_count))
        else $error("stalled result changed or vanished");

endmodule

bind physical_page_allocator_core ppa_checker u_ppa_checker (.*);
